// ===== sv/smart_beacon_scheduler_top_defines.svh =====
// ----------------------------------------------------------------------------
// smart_beacon_scheduler_top_defines.svh
// Assertion macros for the beacon scheduler. They expect clk and rst_n
// in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef SMART_BEACON_SCHEDULER_TOP_DEFINES_SVH
`define SMART_BEACON_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SBS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbs: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define SBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbs: next-cycle check failed");

`endif

// ===== sv/sbs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared widths, register indexes, reset values and the command and status
// bundles between the beacon scheduler controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sbs_pkg;

  // Field widths
  localparam int SPD_W   = 13;  // speed in fractional km/h
  localparam int CRS_W   = 10;  // raw course
  localparam int CRSC_W  = 9;   // clamped course 0..360
  localparam int DLT_W   = 8;   // course change 0..180
  localparam int NOW_W   = 32;  // timestamp
  localparam int INT_W   = 32;  // interval in ms
  localparam int THR_W   = 16;  // corner threshold
  localparam int KMH_W   = 9;
  localparam int RATE_W  = 16;
  localparam int TURN_W  = 8;
  localparam int SLOPE_W = 10;
  localparam int MS_W    = 10;  // width of the ms-per-second factor
  localparam int MSPR_W  = RATE_W + MS_W;

  // Stream beat widths
  localparam int IN_W     = 56;
  localparam int OUT_USED = 3 + INT_W + DLT_W + THR_W;
  localparam int OUT_W    = 64;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_SPEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_RATE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_SLOPE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TURN_T = 3'd6;

  localparam logic [KMH_W-1:0]   RST_LOW_SPEED  = 9'd5;
  localparam logic [KMH_W-1:0]   RST_HIGH_SPEED = 9'd90;
  localparam logic [RATE_W-1:0]  RST_SLOW_RATE  = 16'd1750;
  localparam logic [RATE_W-1:0]  RST_FAST_RATE  = 16'd175;
  localparam logic [TURN_W-1:0]  RST_TURN_MIN   = 8'd30;
  localparam logic [SLOPE_W-1:0] RST_TURN_SLOPE = 10'd240;
  localparam logic [RATE_W-1:0]  RST_MIN_TURN_T = 16'd20;

  // Arithmetic constants
  localparam logic [MS_W-1:0]   MS_PER_S      = 10'd1000;
  localparam logic [KMH_W-1:0]  MAX_SPEED_KMH = 9'd300;
  localparam logic [CRSC_W-1:0] MAX_COURSE    = 9'd360;
  localparam logic [CRSC_W-1:0] HALF_TURN     = 9'd180;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch a fix and the course change
    logic mul1;      // rate products, elapsed time
    logic mul2;      // numerators, start divide
    logic div_step;  // one quotient bit on both lanes
    logic finish;    // decide, update state, load result
  } sbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;  // current divide step is the final one
  } sbs_status_t;

endpackage

`default_nettype wire

// ===== sv/sbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbs_ctrl
// Sequencer for the beacon scheduler: takes one fix, steps the datapath
// through multiply and divide phases, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sbs_ctrl
  import sbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output sbs_cmd_t         cmd,
  input  wire sbs_status_t status
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // no beat is taken while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish)      out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ===== sv/sbs_datapath.sv =====
// ----------------------------------------------------------------------------
// sbs_datapath
// Config registers, beacon state, rate multipliers, two restoring divide
// lanes (interval and corner threshold) and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbs_datapath
  import sbs_pkg::*;
#(
  parameter int SPEED_FRAC_BITS = 4,
  parameter int TIME_BITS       = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic [IN_W-1:0]      in_tdata,
  input  wire sbs_cmd_t             cmd,
  output sbs_status_t               status,
  output logic [OUT_W-1:0]          out_tdata
);

  localparam int LQ_W   = KMH_W + SPEED_FRAC_BITS;
  localparam int CMP_W  = (LQ_W > SPD_W) ? LQ_W : SPD_W;
  localparam int PROD_W = RATE_W + KMH_W;
  localparam int NUM_W  = PROD_W + MS_W + SPEED_FRAC_BITS;
  localparam int TH_W   = SLOPE_W + SPEED_FRAC_BITS;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int ET_W   = (TIME_BITS > INT_W) ? TIME_BITS : INT_W;
  localparam int RS_W   = SPD_W + 1;

  // Configuration registers
  logic [KMH_W-1:0]   low_kmh_r, high_kmh_r;
  logic [RATE_W-1:0]  slow_rate_r, fast_rate_r, min_turn_r;
  logic [TURN_W-1:0]  turn_min_r;
  logic [SLOPE_W-1:0] turn_slope_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_kmh_r    <= RST_LOW_SPEED;
      high_kmh_r   <= RST_HIGH_SPEED;
      slow_rate_r  <= RST_SLOW_RATE;
      fast_rate_r  <= RST_FAST_RATE;
      turn_min_r   <= RST_TURN_MIN;
      turn_slope_r <= RST_TURN_SLOPE;
      min_turn_r   <= RST_MIN_TURN_T;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_SPEED:  low_kmh_r    <= cfg_wdata[KMH_W-1:0];
        REG_HIGH_SPEED: high_kmh_r   <= cfg_wdata[KMH_W-1:0];
        REG_SLOW_RATE:  slow_rate_r  <= cfg_wdata[RATE_W-1:0];
        REG_FAST_RATE:  fast_rate_r  <= cfg_wdata[RATE_W-1:0];
        REG_TURN_MIN:   turn_min_r   <= cfg_wdata[TURN_W-1:0];
        REG_TURN_SLOPE: turn_slope_r <= cfg_wdata[SLOPE_W-1:0];
        REG_MIN_TURN_T: min_turn_r   <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input unpack and clamps
  logic [SPD_W-1:0]  in_speed, speed_c;
  logic [CRS_W-1:0]  in_course;
  logic [CRSC_W-1:0] course_c, course_diff;
  logic [DLT_W-1:0]  delta_c;
  logic [CMP_W-1:0]  max_speed_q;

  // Beacon state
  logic [TIME_BITS-1:0] last_send_r;
  logic [CRSC_W-1:0]    prior_course_r;

  // Per-fix registers
  logic [SPD_W-1:0]     speed_r;
  logic [DLT_W-1:0]     delta_r;
  logic [TIME_BITS-1:0] now_r, elapsed_r;
  logic                 button_r;
  logic [PROD_W-1:0]    prod_r;
  logic [MSPR_W-1:0]    slow_ms_r, fast_ms_r, mtt_ms_r;

  assign in_speed    = in_tdata[SPD_W-1:0];
  assign in_course   = in_tdata[SPD_W +: CRS_W];
  assign max_speed_q = CMP_W'(MAX_SPEED_KMH) << SPEED_FRAC_BITS;

  always_comb begin
    speed_c  = (CMP_W'(in_speed) > max_speed_q) ? '0 : in_speed;
    course_c = (in_course > CRS_W'(MAX_COURSE)) ? '0 : in_course[CRSC_W-1:0];
    course_diff = (prior_course_r > course_c) ? prior_course_r - course_c
                                              : course_c - prior_course_r;
    // wrap across north
    delta_c = (course_diff > HALF_TURN) ? DLT_W'(MAX_COURSE - course_diff)
                                        : DLT_W'(course_diff);
  end

  // Capture and multiply phases
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      speed_r  <= speed_c;
      delta_r  <= delta_c;
      now_r    <= TIME_BITS'(in_tdata[SPD_W+CRS_W +: NOW_W]);
      button_r <= in_tdata[SPD_W+CRS_W+NOW_W];
    end
    if (cmd.mul1) begin
      prod_r    <= PROD_W'(fast_rate_r) * PROD_W'(high_kmh_r);
      slow_ms_r <= MSPR_W'(slow_rate_r) * MSPR_W'(MS_PER_S);
      fast_ms_r <= MSPR_W'(fast_rate_r) * MSPR_W'(MS_PER_S);
      mtt_ms_r  <= MSPR_W'(min_turn_r) * MSPR_W'(MS_PER_S);
      elapsed_r <= now_r - last_send_r;
    end
  end

  // Divide lanes: lane 1 interval numerator, lane 2 threshold slope
  logic [NUM_W-1:0] num1_r, num2_r;
  logic [SPD_W-1:0] rem1_r, rem2_r;
  logic [CNT_W-1:0] cnt_r;
  logic [RS_W-1:0]  rs1, rs2, dvs;
  logic             ge1, ge2;

  always_comb begin
    dvs = {1'b0, speed_r};
    rs1 = {rem1_r, num1_r[NUM_W-1]};
    rs2 = {rem2_r, num2_r[NUM_W-1]};
    ge1 = (rs1 >= dvs);
    ge2 = (rs2 >= dvs);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul2) begin
      num1_r <= (NUM_W'(prod_r) * NUM_W'(MS_PER_S)) << SPEED_FRAC_BITS;
      num2_r <= NUM_W'(turn_slope_r) << SPEED_FRAC_BITS;
      rem1_r <= '0;
      rem2_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      num1_r <= {num1_r[NUM_W-2:0], ge1};
      num2_r <= {num2_r[NUM_W-2:0], ge2};
      rem1_r <= ge1 ? SPD_W'(rs1 - dvs) : SPD_W'(rs1);
      rem2_r <= ge2 ? SPD_W'(rs2 - dvs) : SPD_W'(rs2);
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  assign status.div_last = (cnt_r == CNT_W'(NUM_W - 1));

  // Decision
  logic [CMP_W-1:0] spd_x, low_q, high_q;
  logic [INT_W-1:0] interval;
  logic [TH_W:0]    thr_sum;
  logic [THR_W-1:0] thr;
  logic             corner, periodic;

  always_comb begin
    spd_x  = CMP_W'(speed_r);
    low_q  = CMP_W'(low_kmh_r) << SPEED_FRAC_BITS;
    high_q = CMP_W'(high_kmh_r) << SPEED_FRAC_BITS;

    if (spd_x < low_q)           interval = INT_W'(slow_ms_r);
    else if (spd_x > high_q)     interval = INT_W'(fast_ms_r);
    else if (speed_r == '0)      interval = '1;
    else if (|num1_r[NUM_W-1:INT_W]) interval = '1;
    else                         interval = num1_r[INT_W-1:0];

    thr_sum = (TH_W+1)'(turn_min_r) + (TH_W+1)'(num2_r[TH_W-1:0]);
    if (speed_r == '0 || 32'(thr_sum) > 32'(16'hFFFF)) thr = '1;
    else                                              thr = THR_W'(thr_sum);

    corner   = (THR_W'(delta_r) > thr) && (ET_W'(elapsed_r) > ET_W'(mtt_ms_r));
    // a corner beacon restarts the clock, so no periodic beacon with it
    periodic = !corner && (ET_W'(elapsed_r) > ET_W'(interval));
  end

  // State update and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_send_r    <= '0;
      prior_course_r <= '0;
    end else begin
      if (cmd.capture) prior_course_r <= course_c;
      if (cmd.finish && (corner || periodic)) last_send_r <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_tdata <= {(OUT_W-OUT_USED)'(0), thr, delta_r, interval,
                    button_r, periodic, corner};
    end
  end

endmodule

`default_nettype wire

// ===== sv/smart_beacon_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// smart_beacon_scheduler_top
// Beacon decision per GPS fix: speed-dependent interval, corner threshold,
// corner / periodic / manual flags.
//
// Usage:
//   in_*   one beat per fix: speed, course, ms timestamp, button level.
//   out_*  one beat per fix: the three send flags, interval in ms, course
//          change and corner threshold.
//   cfg_*  register writes, one per cycle with cfg_we high; write only while
//          no fix is in flight. Index 7 is ignored.
//   A fix is captured, passes the multiply phases and the divide, and its
//   result is loaded once the output register is free. The block takes one
//   fix at a time and accepts the next after the result is loaded. The
//   divider is restoring, one quotient bit a cycle over a 35 + SPEED_FRAC_BITS
//   bit numerator, with both divisions run side by side.
//   Reset loads the register defaults and clears last send time and course.
//   A stalled receiver holds the result; a new fix is still taken and
//   computed, and waits before its result register load until the old beat
//   is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "smart_beacon_scheduler_top_defines.svh"

module smart_beacon_scheduler_top
  import sbs_pkg::*;
#(
  parameter int SPEED_FRAC_BITS = 4,
  parameter int TIME_BITS       = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // speed_q[12:0], course_deg[22:13], now_ms[54:23], button_pressed[55]
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_W-1:0]      in_tdata,
  // send_corner[0], send_periodic[1], send_manual[2], interval_ms[34:3],
  // course_change[42:35], corner_threshold[58:43], zero[63:59]
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [OUT_W-1:0]          out_tdata,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  sbs_cmd_t    cmd;
  sbs_status_t status;

  sbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  sbs_datapath #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
    .TIME_BITS       (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

  // Checks
  `SBS_ASSERT_SAME(a_finish_slot_free, cmd.finish, !out_tvalid || out_tready)
  `SBS_ASSERT_NEXT(a_finish_valid, cmd.finish, out_tvalid)
  `SBS_ASSERT_NEXT(a_one_fix_in_flight, in_tvalid && in_tready, !in_tready)

endmodule

`default_nettype wire
